FILE: rtl/matrix2x2_arith_unit_macros.svh
// Assertion macros shared by the matrix unit RTL.
// Used by files that carry concurrent assertions; no other dependencies.
`ifndef MATRIX2X2_ARITH_UNIT_MACROS_SVH
`define MATRIX2X2_ARITH_UNIT_MACROS_SVH
`ifndef SYNTH
`define M2X2_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define M2X2_ASSERT_NEXT(name, clk, rst, cond, nxt) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("assertion failed");
`else
`define M2X2_ASSERT(name, clk, rst, prop)
`define M2X2_ASSERT_NEXT(name, clk, rst, cond, nxt)
`endif
`endif

FILE: rtl/m2x2_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation and status codes, and the saturation function
// of the matrix unit. No dependencies.
package m2x2_pkg;
   localparam int ELEM_W        = 32;
   localparam int WIDE_W        = 66;
   localparam int PROD_W        = 64;
   localparam int LIN_W         = 33;
   localparam int OP_W          = 4;
   localparam int STAT_W        = 2;
   localparam int THR_W         = 31;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
   localparam logic [OP_W-1:0] OP_SCALE = 4'd3;
   localparam logic [OP_W-1:0] OP_TRANS = 4'd4;
   localparam logic [OP_W-1:0] OP_COF   = 4'd5;
   localparam logic [OP_W-1:0] OP_ADJ   = 4'd6;
   localparam logic [OP_W-1:0] OP_INV   = 4'd7;
   localparam logic [OP_W-1:0] OP_DET   = 4'd8;
   localparam logic [OP_W-1:0] OP_TRACE = 4'd9;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_SAT      = 2'd1;
   localparam logic [STAT_W-1:0] ST_SINGULAR = 2'd2;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic     sat;
      elem_type val;
   } clamp_type;

   typedef struct packed {
      logic                  is_inv;
      logic                  singular;
      logic [3:0]            neg;
      elem_type [3:0]        r;
      elem_type              scal;
      logic [STAT_W-1:0]     status;
   } side_type;

   function automatic clamp_type sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      clamp_type res;
      hi = {{(WIDE_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
      lo = {{(WIDE_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};
      if (v > hi) begin
         res.sat = 1'b1;
         res.val = {1'b0, {(ELEM_W-1){1'b1}}};
      end else if (v < lo) begin
         res.sat = 1'b1;
         res.val = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         res.sat = 1'b0;
         res.val = v[ELEM_W-1:0];
      end
      return res;
   endfunction
endpackage

FILE: rtl/matrix2x2_arith_unit.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the divider retires one quotient bit per stage.
// The whole pipeline holds while a result waits at the output register.
// Reset is synchronous, active high; it empties the pipeline and clears the threshold.
// Top level of the 2x2 matrix unit. Depends on m2x2_pkg, m2x2_front, m2x2_div
// and matrix2x2_arith_unit_macros.svh.
`include "matrix2x2_arith_unit_macros.svh"
module matrix2x2_arith_unit import m2x2_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // a_row0_col0, a_row0_col1, a_row1_col0, a_row1_col1,
   // b_row0_col0, b_row0_col1, b_row1_col0, b_row1_col1, scale_factor
   input  logic [9*ELEM_W-1:0]   req_tdata,
   // req_type
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // r_row0_col0, r_row0_col1, r_row1_col0, r_row1_col1, scalar_result
   output logic [5*ELEM_W-1:0]   rsp_tdata,
   // status
   output logic [STAT_W-1:0]     rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [THR_W-1:0]      csr_data
);
   localparam int NW  = ELEM_W + FRAC_BITS;
   localparam int DVW = 64 - FRAC_BITS;

   logic               en;
   logic [THR_W-1:0]   thr_ff;
   elem_type [3:0]     a;
   elem_type [3:0]     b;
   logic               fv;
   side_type           fside;
   logic [3:0][NW-1:0] num;
   logic [DVW-1:0]     den;
   logic [3:0][NW-1:0] quot;

   side_type           side_ff [0:NW-1];
   logic [NW-1:0]      vld_ff;

   logic               out_v_ff;
   logic [5*ELEM_W-1:0] out_d_ff;
   logic [5*ELEM_W-1:0] out_d_in;
   logic [STAT_W-1:0]  out_s_ff;
   logic [STAT_W-1:0]  out_s_in;

   side_type           last;
   elem_type           qv [0:3];
   logic               qsat;
   logic [NW-1:0]      pos_lim;
   logic [NW-1:0]      neg_lim;

   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         a[e] = req_tdata[e*ELEM_W +: ELEM_W];
         b[e] = req_tdata[(e+4)*ELEM_W +: ELEM_W];
      end
   end

   m2x2_front #(.FRAC_BITS(FRAC_BITS), .NW(NW), .DVW(DVW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .op        (req_tuser),
      .a         (a),
      .b         (b),
      .s         (req_tdata[8*ELEM_W +: ELEM_W]),
      .thr       (thr_ff),
      .out_valid (fv),
      .side      (fside),
      .num_mag   (num),
      .den_mag   (den)
   );

   m2x2_div #(.NW(NW), .DVW(DVW)) u_div (
      .clock (clock),
      .en    (en),
      .num   (num),
      .den   (den),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NW-2:0], fv};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= fside;
         for (int k = 1; k < NW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      last    = side_ff[NW-1];
      pos_lim = NW'({(ELEM_W-1){1'b1}});
      neg_lim = NW'({1'b1, {(ELEM_W-1){1'b0}}});
      qsat    = 1'b0;
      for (int e = 0; e < 4; e++) begin
         if (last.neg[e]) begin
            if (quot[e] > neg_lim) begin
               qsat  = 1'b1;
               qv[e] = {1'b1, {(ELEM_W-1){1'b0}}};
            end else begin
               qv[e] = -quot[e][ELEM_W-1:0];
            end
         end else begin
            if (quot[e] > pos_lim) begin
               qsat  = 1'b1;
               qv[e] = {1'b0, {(ELEM_W-1){1'b1}}};
            end else begin
               qv[e] = quot[e][ELEM_W-1:0];
            end
         end
      end
      if (!last.is_inv) begin
         out_d_in = {last.scal, last.r[3], last.r[2], last.r[1], last.r[0]};
         out_s_in = last.status;
      end else if (last.singular) begin
         out_d_in = '0;
         out_s_in = ST_SINGULAR;
      end else begin
         out_d_in = {{ELEM_W{1'b0}}, qv[3], qv[2], qv[1], qv[0]};
         out_s_in = qsat ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= vld_ff[NW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_d_ff <= out_d_in;
         out_s_ff <= out_s_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_s_ff;

   `M2X2_ASSERT(a_singular_zero, clock, reset, (rsp_tvalid && rsp_tuser == ST_SINGULAR) |-> (rsp_tdata == '0))
   `M2X2_ASSERT(a_scalar_no_matrix, clock, reset, (rsp_tvalid && rsp_tdata[5*ELEM_W-1:4*ELEM_W] != '0) |-> (rsp_tdata[4*ELEM_W-1:0] == '0))
   `M2X2_ASSERT(a_stall_only_full, clock, reset, !req_tready |-> rsp_tvalid)
   `M2X2_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_tvalid && !rsp_tready, $stable(vld_ff))
endmodule

FILE: rtl/m2x2_front.sv
`timescale 1ns / 1ps
// Front end of the matrix unit: input capture, multipliers, sums with saturation,
// determinant and divider operands. Depends on m2x2_pkg.
module m2x2_front import m2x2_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int NW        = ELEM_W + FRAC_BITS,
   parameter int DVW       = PROD_W - FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [OP_W-1:0]      op,
   input  elem_type [3:0]       a,
   input  elem_type [3:0]       b,
   input  elem_type             s,
   input  logic [THR_W-1:0]     thr,
   output logic                 out_valid,
   output side_type             side,
   output logic [3:0][NW-1:0]   num_mag,
   output logic [DVW-1:0]       den_mag
);
   logic              f1_v_ff;
   logic [OP_W-1:0]   f1_op_ff;
   elem_type [3:0]    f1_a_ff;
   elem_type [3:0]    f1_b_ff;
   elem_type          f1_s_ff;

   logic                     f2_v_ff;
   logic [OP_W-1:0]          f2_op_ff;
   logic signed [PROD_W-1:0] pm_ff [0:3][0:1];
   logic signed [PROD_W-1:0] ps_ff [0:3];
   logic signed [PROD_W-1:0] pd_ff [0:1];
   logic signed [LIN_W-1:0]  lin_ff [0:3];
   logic signed [LIN_W-1:0]  tr_ff;
   logic [ELEM_W-1:0]        adjmag_ff [0:3];
   logic [3:0]               adjneg_ff;

   logic signed [LIN_W-1:0]  ax [0:3];
   logic signed [LIN_W-1:0]  bx [0:3];
   logic signed [LIN_W-1:0]  adj [0:3];
   logic signed [LIN_W-1:0]  lin_in [0:3];

   logic                     f3_v_ff;
   side_type                 side_ff;
   side_type                 side_in;
   logic [3:0][NW-1:0]       num_ff;
   logic [3:0][NW-1:0]       num_in;
   logic [DVW-1:0]           den_ff;
   logic [DVW-1:0]           den_in;

   logic signed [WIDE_W-1:0] w [0:3];
   logic signed [WIDE_W-1:0] det;
   logic signed [WIDE_W-1:0] dmag;
   clamp_type                c [0:3];
   clamp_type                cs;
   logic                     sat_any;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= in_valid;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_op_ff <= op;
         f1_a_ff  <= a;
         f1_b_ff  <= b;
         f1_s_ff  <= s;
      end
   end

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         ax[e] = LIN_W'(f1_a_ff[e]);
         bx[e] = LIN_W'(f1_b_ff[e]);
      end
      adj[0] = ax[3];
      adj[1] = -ax[1];
      adj[2] = -ax[2];
      adj[3] = ax[0];
      for (int e = 0; e < 4; e++) begin
         case (f1_op_ff)
            OP_ADD:   lin_in[e] = ax[e] + bx[e];
            OP_SUB:   lin_in[e] = ax[e] - bx[e];
            OP_TRANS: lin_in[e] = ax[{e[0], e[1]}];
            OP_COF:   lin_in[e] = adj[{e[0], e[1]}];
            OP_ADJ:   lin_in[e] = adj[e];
            default:  lin_in[e] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_op_ff <= f1_op_ff;
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
               for (int k = 0; k < 2; k++) begin
                  pm_ff[i*2+j][k] <= f1_a_ff[i*2+k] * f1_b_ff[k*2+j];
               end
            end
         end
         for (int e = 0; e < 4; e++) begin
            ps_ff[e]     <= f1_s_ff * f1_a_ff[e];
            lin_ff[e]    <= lin_in[e];
            adjneg_ff[e] <= adj[e][LIN_W-1];
            adjmag_ff[e] <= adj[e][LIN_W-1] ? ELEM_W'(-adj[e]) : ELEM_W'(adj[e]);
         end
         pd_ff[0] <= f1_a_ff[0] * f1_a_ff[3];
         pd_ff[1] <= f1_a_ff[1] * f1_a_ff[2];
         tr_ff    <= ax[0] + ax[3];
      end
   end

   always_comb begin
      sat_any = 1'b0;
      for (int e = 0; e < 4; e++) begin
         case (f2_op_ff)
            OP_MUL:   w[e] = (WIDE_W'(pm_ff[e][0]) + WIDE_W'(pm_ff[e][1])) >>> FRAC_BITS;
            OP_SCALE: w[e] = WIDE_W'(ps_ff[e]) >>> FRAC_BITS;
            OP_ADD, OP_SUB, OP_TRANS, OP_COF, OP_ADJ: w[e] = WIDE_W'(lin_ff[e]);
            default:  w[e] = '0;
         endcase
         c[e]          = sat32(w[e]);
         sat_any       = sat_any | c[e].sat;
         side_in.r[e]  = c[e].val;
         side_in.neg[e] = 1'b0;
         num_in[e]     = NW'(adjmag_ff[e]) << FRAC_BITS;
      end
      det  = (WIDE_W'(pd_ff[0]) - WIDE_W'(pd_ff[1])) >>> FRAC_BITS;
      dmag = det[WIDE_W-1] ? -det : det;
      den_in = dmag[DVW-1:0];
      for (int e = 0; e < 4; e++) begin
         side_in.neg[e] = adjneg_ff[e] ^ det[WIDE_W-1];
      end
      side_in.singular = dmag <= WIDE_W'(thr);
      side_in.is_inv   = f2_op_ff == OP_INV;
      case (f2_op_ff)
         OP_DET:   cs = sat32(det);
         OP_TRACE: cs = sat32(WIDE_W'(tr_ff));
         default:  cs = '0;
      endcase
      side_in.scal   = cs.val;
      side_in.status = (sat_any | cs.sat) ? ST_SAT : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign out_valid = f3_v_ff;
   assign side      = side_ff;
   assign num_mag   = num_ff;
   assign den_mag   = den_ff;
endmodule

FILE: rtl/m2x2_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, four numerators
// sharing one divisor. Depends on m2x2_pkg.
module m2x2_div import m2x2_pkg::*; #(
   parameter int NW  = ELEM_W + FRAC_BITS_DEF,
   parameter int DVW = 64 - FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic [3:0][NW-1:0] num,
   input  logic [DVW-1:0]     den,
   output logic [3:0][NW-1:0] quot
);
   logic [DVW-1:0] rem_ff [0:NW-1][0:3];
   logic [NW-1:0]  nq_ff  [0:NW-1][0:3];
   logic [DVW-1:0] dv_ff  [0:NW-1];

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DVW-1:0] r_cur [0:3];
      logic [NW-1:0]  n_cur [0:3];
      logic [DVW-1:0] d_cur;
      logic [DVW:0]   t [0:3];
      logic [3:0]     ge;
      logic [DVW-1:0] rem_in [0:3];
      logic [NW-1:0]  nq_in [0:3];

      if (k == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 4; l++) begin
               r_cur[l] = '0;
               n_cur[l] = num[l];
            end
            d_cur = den;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < 4; l++) begin
               r_cur[l] = rem_ff[k-1][l];
               n_cur[l] = nq_ff[k-1][l];
            end
            d_cur = dv_ff[k-1];
         end
      end

      always_comb begin
         for (int l = 0; l < 4; l++) begin
            t[l]      = {r_cur[l], n_cur[l][NW-1]};
            ge[l]     = t[l] >= {1'b0, d_cur};
            rem_in[l] = ge[l] ? DVW'(t[l] - {1'b0, d_cur}) : t[l][DVW-1:0];
            nq_in[l]  = {n_cur[l][NW-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 4; l++) begin
               rem_ff[k][l] <= rem_in[l];
               nq_ff[k][l]  <= nq_in[l];
            end
            dv_ff[k] <= d_cur;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         quot[l] = nq_ff[NW-1][l];
      end
   end
endmodule
